/* src/tdr_pkg.sv */
package tdr_pkg;

  // action codes
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_DRAW  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam int ZW     = 17;  // depth, Q1.16
  localparam int CW_CNT = 19;  // write count
  localparam int CRD_W  = 12;  // pixel coordinate, map up to 4096
  localparam int SW     = 21;  // edge step per pixel
  localparam int EW     = 36;  // edge value and area
  localparam int NW     = 56;  // depth numerator
  localparam int QBITS  = 17;  // quotient bits before saturation
  localparam int Q_DEPTH = 2;  // command queue entries

  localparam logic [ZW-1:0]     DEPTH_ONE = 17'd65536;
  localparam logic [CW_CNT-1:0] COUNT_MAX = 19'h7FFFF;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] vertex_a_x;
    logic signed [15:0] vertex_a_y;
    logic [ZW-1:0]      vertex_a_z;
    logic signed [15:0] vertex_b_x;
    logic signed [15:0] vertex_b_y;
    logic [ZW-1:0]      vertex_b_z;
    logic signed [15:0] vertex_c_x;
    logic signed [15:0] vertex_c_y;
    logic [ZW-1:0]      vertex_c_z;
    logic [8:0]         read_col;
    logic [8:0]         read_row;
  } req_t;

  typedef struct packed {
    logic [1:0]        done_kind;
    logic [ZW-1:0]     depth_value;
    logic [CW_CNT-1:0] pixels_written;
  } rsp_t;

  // one classified command, with the triangle set up for stepping
  typedef struct packed {
    logic [1:0]           action;
    logic [8:0]           read_col;
    logic [8:0]           read_row;
    logic                 empty;
    logic                 area_zero;
    logic [CRD_W-1:0]     x0;
    logic [CRD_W-1:0]     y0;
    logic [CRD_W-1:0]     x1;
    logic [CRD_W-1:0]     y1;
    logic signed [EW-1:0] e1;
    logic signed [EW-1:0] e2;
    logic signed [EW-1:0] e3;
    logic signed [SW-1:0] dc1;
    logic signed [SW-1:0] dc2;
    logic signed [SW-1:0] dc3;
    logic signed [SW-1:0] dr1;
    logic signed [SW-1:0] dr2;
    logic signed [SW-1:0] dr3;
    logic signed [NW-1:0] num;
    logic signed [NW-1:0] dnc;
    logic signed [NW-1:0] dnr;
    logic [EW-1:0]        den;
  } cmd_t;

endpackage

/* src/tdr_ram.sv */
module tdr_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/tdr_front.sv */
module tdr_front #(
  parameter int MAP_WIDTH  = 512,
  parameter int MAP_HEIGHT = 512
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          hold,
  input  logic          req_valid,
  output logic          req_ready,
  input  tdr_pkg::req_t req,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output tdr_pkg::cmd_t cmd
);

  localparam int EW = tdr_pkg::EW;
  localparam int SW = tdr_pkg::SW;
  localparam int NW = tdr_pkg::NW;
  localparam int CRD_W = tdr_pkg::CRD_W;
  localparam logic [CRD_W:0] W_LAST = (CRD_W+1)'(MAP_WIDTH - 1);
  localparam logic [CRD_W:0] H_LAST = (CRD_W+1)'(MAP_HEIGHT - 1);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_SET  = 5'b00010,
    F_MUL  = 5'b00100,
    F_ZMUL = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t state;
  tdr_pkg::req_t item;

  logic signed [16:0] dx1, dx2, dx3, dy1, dy2, dy3;
  logic signed [17:0] ox1, ox2, ox3, oy1, oy2, oy3;
  logic [CRD_W-1:0]   x0, y0, x1, y1;
  logic               empty;
  logic signed [EW-1:0] e1, e2, e3, area;
  logic signed [SW-1:0] dc1, dc2, dc3, dr1, dr2, dr3;
  logic signed [NW-1:0] pn1, pn2, pn3, pc1, pc2, pc3, pr1, pr2, pr3;

  // box and vertex differences from the held item
  logic signed [16:0] ax, ay, bx, by, cx, cy;
  logic signed [16:0] mnx, mny, mxx, mxy, vx, vy;
  logic [CRD_W-1:0]   bx0, by0, rx1, ry1, cx1, cy1;
  logic               nx1, ny1;
  logic signed [17:0] px, py;

  always_comb begin
    ax = 17'(item.vertex_a_x);
    ay = 17'(item.vertex_a_y);
    bx = 17'(item.vertex_b_x);
    by = 17'(item.vertex_b_y);
    cx = 17'(item.vertex_c_x);
    cy = 17'(item.vertex_c_y);
    mnx = (ax < bx) ? ax : bx;
    mnx = (mnx < cx) ? mnx : cx;
    mny = (ay < by) ? ay : by;
    mny = (mny < cy) ? mny : cy;
    mxx = (ax > bx) ? ax : bx;
    mxx = (mxx > cx) ? mxx : cx;
    mxy = (ay > by) ? ay : by;
    mxy = (mxy > cy) ? mxy : cy;
    // start truncates toward zero, so anything negative lands on column zero
    bx0 = mnx[16] ? '0 : {1'b0, mnx[14:4]};
    by0 = mny[16] ? '0 : {1'b0, mny[14:4]};
    vx = mxx + 17'sd8;
    vy = mxy + 17'sd8;
    nx1 = (vx <= -17'sd16);
    ny1 = (vy <= -17'sd16);
    rx1 = vx[16] ? '0 : vx[15:4];
    ry1 = vy[16] ? '0 : vy[15:4];
    cx1 = ({1'b0, rx1} > W_LAST) ? W_LAST[CRD_W-1:0] : rx1;
    cy1 = ({1'b0, ry1} > H_LAST) ? H_LAST[CRD_W-1:0] : ry1;
    px = $signed({2'b00, bx0, 4'b0000});
    py = $signed({2'b00, by0, 4'b0000});
  end

  assign req_ready = (state == F_IDLE) && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (req_valid && req_ready) begin
            state <= (req.action == tdr_pkg::ACT_DRAW) ? F_SET : F_PUSH;
          end
        end
        F_SET:  state <= F_MUL;
        F_MUL:  state <= F_ZMUL;
        F_ZMUL: state <= F_PUSH;
        F_PUSH: begin
          if (cmd_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && req_valid && req_ready) begin
      item <= req;
    end
    if (state == F_SET) begin
      dx1 <= bx - ax;  dy1 <= by - ay;
      dx2 <= cx - bx;  dy2 <= cy - by;
      dx3 <= ax - cx;  dy3 <= ay - cy;
      ox1 <= px - 18'(ax);  oy1 <= py - 18'(ay);
      ox2 <= px - 18'(bx);  oy2 <= py - 18'(by);
      ox3 <= px - 18'(cx);  oy3 <= py - 18'(cy);
      x0 <= bx0;  y0 <= by0;  x1 <= cx1;  y1 <= cy1;
      empty <= nx1 || ny1 || (bx0 > cx1) || (by0 > cy1);
    end
    if (state == F_MUL) begin
      e1 <= EW'(dx1) * EW'(oy1) - EW'(dy1) * EW'(ox1);
      e2 <= EW'(dx2) * EW'(oy2) - EW'(dy2) * EW'(ox2);
      e3 <= EW'(dx3) * EW'(oy3) - EW'(dy3) * EW'(ox3);
      area <= EW'(dy2) * EW'(dx3) - EW'(dy3) * EW'(dx2);
      dc1 <= -$signed({dy1, 4'b0000});
      dc2 <= -$signed({dy2, 4'b0000});
      dc3 <= -$signed({dy3, 4'b0000});
      dr1 <= $signed({dx1, 4'b0000});
      dr2 <= $signed({dx2, 4'b0000});
      dr3 <= $signed({dx3, 4'b0000});
    end
    if (state == F_ZMUL) begin
      // vertex a weight is edge bc, b is edge ca, c is edge ab
      pn1 <= NW'(e2) * NW'($signed({1'b0, item.vertex_a_z}));
      pn2 <= NW'(e3) * NW'($signed({1'b0, item.vertex_b_z}));
      pn3 <= NW'(e1) * NW'($signed({1'b0, item.vertex_c_z}));
      pc1 <= NW'(dc2) * NW'($signed({1'b0, item.vertex_a_z}));
      pc2 <= NW'(dc3) * NW'($signed({1'b0, item.vertex_b_z}));
      pc3 <= NW'(dc1) * NW'($signed({1'b0, item.vertex_c_z}));
      pr1 <= NW'(dr2) * NW'($signed({1'b0, item.vertex_a_z}));
      pr2 <= NW'(dr3) * NW'($signed({1'b0, item.vertex_b_z}));
      pr3 <= NW'(dr1) * NW'($signed({1'b0, item.vertex_c_z}));
    end
  end

  // fold the area sign into the numerator so the back end divides by |area|
  logic signed [NW-1:0] sn, sc, sr;
  logic                 area_neg;

  always_comb begin
    area_neg = area[EW-1];
    sn = pn1 + pn2 + pn3;
    sc = pc1 + pc2 + pc3;
    sr = pr1 + pr2 + pr3;
    cmd.action    = item.action;
    cmd.read_col  = item.read_col;
    cmd.read_row  = item.read_row;
    cmd.empty     = empty;
    cmd.area_zero = (area == '0);
    cmd.x0 = x0;  cmd.y0 = y0;  cmd.x1 = x1;  cmd.y1 = y1;
    cmd.e1 = e1;  cmd.e2 = e2;  cmd.e3 = e3;
    cmd.dc1 = dc1;  cmd.dc2 = dc2;  cmd.dc3 = dc3;
    cmd.dr1 = dr1;  cmd.dr2 = dr2;  cmd.dr3 = dr3;
    cmd.num = area_neg ? sn : -sn;
    cmd.dnc = area_neg ? sc : -sc;
    cmd.dnr = area_neg ? sr : -sr;
    cmd.den = area_neg ? EW'(-area) : EW'(area);
  end

  assign cmd_valid = (state == F_PUSH);

endmodule

/* src/tdr_queue.sv */
module tdr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  tdr_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tdr_pkg::cmd_t pop_data
);

  localparam int D  = tdr_pkg::Q_DEPTH;
  localparam int PW = $clog2(D);

  tdr_pkg::cmd_t slots [D];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;
  logic          do_push, do_pop;

  assign push_ready = (count != (PW+1)'(D));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(D - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(D - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

/* src/tdr_back.sv */
module tdr_back #(
  parameter int MAP_WIDTH  = 512,
  parameter int MAP_HEIGHT = 512
) (
  input  logic          clk,
  input  logic          rst,
  output logic          init_busy,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  tdr_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output tdr_pkg::rsp_t rsp
);

  localparam int N  = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW = $clog2(N);
  localparam int EW = tdr_pkg::EW;
  localparam int NW = tdr_pkg::NW;
  localparam int ZW = tdr_pkg::ZW;
  localparam int QB = tdr_pkg::QBITS;
  localparam int CRD_W = tdr_pkg::CRD_W;
  localparam int KW = $clog2(QB);

  typedef enum logic [8:0] {
    B_INIT  = 9'b000000001,
    B_IDLE  = 9'b000000010,
    B_CLEAR = 9'b000000100,
    B_READ  = 9'b000001000,
    B_RDATA = 9'b000010000,
    B_PIX   = 9'b000100000,
    B_DIV   = 9'b001000000,
    B_CMP   = 9'b010000000,
    B_DONE  = 9'b100000000
  } bstate_t;

  bstate_t state;
  tdr_pkg::cmd_t cur;

  logic [CRD_W-1:0]     col, row;
  logic signed [EW-1:0] e1, e2, e3, er1, er2, er3;
  logic signed [NW-1:0] num, numr;
  logic [NW-1:0]        rem, dsh;
  logic [QB-1:0]        q;
  logic [KW-1:0]        k;
  logic [ZW-1:0]        dval, rd_depth;
  logic [tdr_pkg::CW_CNT-1:0] count;
  logic [AW-1:0]        clr_addr;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [ZW-1:0] ram_wdata, ram_rdata;

  logic [AW-1:0] pix_addr, rd_addr;
  logic          rd_in_range, covered, sat, hit, last_col, last_row;
  logic [NW-1:0] rem_sub;
  logic          ge;
  logic [QB-1:0] q_next;

  always_comb begin
    pix_addr = AW'(32'(row) * MAP_WIDTH + 32'(col));
    rd_addr  = AW'(32'(cur.read_row) * MAP_WIDTH + 32'(cur.read_col));
    rd_in_range = (32'(cur.read_col) < MAP_WIDTH) && (32'(cur.read_row) < MAP_HEIGHT);
    covered = !cur.area_zero &&
              ((e1 > 0 && e2 > 0 && e3 > 0) || (e1 < 0 && e2 < 0 && e3 < 0));
    sat = (NW'(num) >= (NW'(cur.den) << QB));
    ge = (rem >= dsh);
    rem_sub = rem - dsh;
    q_next = {q[QB-2:0], ge};
    hit = (dval < ram_rdata);
    last_col = (col == cur.x1);
    last_row = (row == cur.y1);
  end

  // memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = tdr_pkg::DEPTH_ONE;
    ram_re    = 1'b0;
    ram_raddr = pix_addr;
    case (state)
      B_INIT, B_CLEAR: ram_we = 1'b1;
      B_READ: begin
        ram_re    = rd_in_range;
        ram_raddr = rd_addr;
      end
      B_PIX: ram_re = covered;
      B_CMP: begin
        ram_we    = hit;
        ram_waddr = pix_addr;
        ram_wdata = dval;
      end
      default: ram_we = 1'b0;
    endcase
  end

  tdr_ram #(.WIDTH(ZW), .DEPTH(N)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign init_busy = (state == B_INIT);
  assign cmd_ready = (state == B_IDLE);

  logic step;
  assign step = (state == B_PIX && !covered) || (state == B_CMP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_INIT;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == B_DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        B_INIT: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(N - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (cmd_valid) begin
            clr_addr <= '0;
            case (cmd.action)
              tdr_pkg::ACT_CLEAR: state <= B_CLEAR;
              tdr_pkg::ACT_READ:  state <= B_READ;
              tdr_pkg::ACT_DRAW:  state <= cmd.empty ? B_DONE : B_PIX;
              default:            state <= B_DONE;
            endcase
          end
        end
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(N - 1)) begin
            state <= B_DONE;
          end
        end
        B_READ:  state <= B_RDATA;
        B_RDATA: state <= B_DONE;
        B_PIX: begin
          if (covered) begin
            state <= (num > 0 && !sat) ? B_DIV : B_CMP;
          end else if (last_col && last_row) begin
            state <= B_DONE;
          end
        end
        B_DIV: begin
          if (k == '0) begin
            state <= B_CMP;
          end
        end
        B_CMP: begin
          state <= (last_col && last_row) ? B_DONE : B_PIX;
        end
        B_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && cmd_valid) begin
      cur      <= cmd;
      col      <= cmd.x0;
      row      <= cmd.y0;
      e1 <= cmd.e1;  e2 <= cmd.e2;  e3 <= cmd.e3;
      er1 <= cmd.e1; er2 <= cmd.e2; er3 <= cmd.e3;
      num      <= cmd.num;
      numr     <= cmd.num;
      count    <= '0;
      rd_depth <= '0;
    end
    if (state == B_RDATA) begin
      rd_depth <= rd_in_range ? ram_rdata : '0;
    end
    if (state == B_PIX && covered) begin
      // non-positive numerators clamp to zero; big quotients clamp to one
      if (num <= 0) begin
        dval <= '0;
      end else if (sat) begin
        dval <= tdr_pkg::DEPTH_ONE;
      end
      rem <= NW'(num);
      dsh <= NW'(cur.den) << (QB - 1);
      q   <= '0;
      k   <= KW'(QB - 1);
    end
    if (state == B_DIV) begin
      if (ge) begin
        rem <= rem_sub;
      end
      dsh <= dsh >> 1;
      q   <= q_next;
      k   <= k - 1'b1;
      if (k == '0) begin
        dval <= (q_next > tdr_pkg::DEPTH_ONE) ? tdr_pkg::DEPTH_ONE : q_next;
      end
    end
    if (state == B_CMP && hit && count != tdr_pkg::COUNT_MAX) begin
      count <= count + 1'b1;
    end
    if (step) begin
      if (!last_col) begin
        col <= col + 1'b1;
        e1  <= e1 + EW'(cur.dc1);
        e2  <= e2 + EW'(cur.dc2);
        e3  <= e3 + EW'(cur.dc3);
        num <= num + cur.dnc;
      end else if (!last_row) begin
        row  <= row + 1'b1;
        col  <= cur.x0;
        e1   <= er1 + EW'(cur.dr1);
        e2   <= er2 + EW'(cur.dr2);
        e3   <= er3 + EW'(cur.dr3);
        er1  <= er1 + EW'(cur.dr1);
        er2  <= er2 + EW'(cur.dr2);
        er3  <= er3 + EW'(cur.dr3);
        num  <= numr + cur.dnr;
        numr <= numr + cur.dnr;
      end
    end
    if (state == B_DONE && (!rsp_valid || rsp_ready)) begin
      rsp.done_kind      <= cur.action;
      rsp.depth_value    <= rd_depth;
      rsp.pixels_written <= count;
    end
  end

endmodule

/* src/triangle_depth_rasterizer_unit.sv */
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    tdr_pkg::req_t (action, vertices, read pixel)
// rsp       out        rsp_valid/rsp_ready    tdr_pkg::rsp_t (kind, depth, write count)
//
// Reset runs a clearing pass over the depth store, one entry a cycle; req_ready stays
// low until it ends. Clear rewrites every entry before raising rsp_valid; read fetches
// one entry (zero outside the map). Draw is set up in the front (F_SET, F_MUL, F_ZMUL),
// then walks the box at one cycle per pixel outside the triangle; a covered pixel runs
// a 17-step restoring divide by |area|, or clamps its depth without dividing, before a
// depth test and write. The pixel walk and its divider set the draw time.
// A two-entry command queue lets the front take and set up items while the back is busy;
// a waiting result sits in the output register and stalls only the back.
module triangle_depth_rasterizer_unit #(
  parameter int MAP_WIDTH  = 512,
  parameter int MAP_HEIGHT = 512
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tdr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output tdr_pkg::rsp_t rsp
);

  logic          init_busy;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  tdr_pkg::cmd_t push_cmd, pop_cmd;

  // classify and set up triangles; hold off input during the reset clearing pass
  tdr_front #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (init_busy),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (push_valid),
    .cmd_ready (push_ready),
    .cmd       (push_cmd)
  );

  // decouple setup from the pixel walk
  tdr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_cmd)
  );

  // walk pixels, divide, test and update the depth store, then transfer the result
  tdr_back #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_back (
    .clk       (clk),
    .rst       (rst),
    .init_busy (init_busy),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
